[hdl/nec_ir_pkg.sv]
// Shared types and constants for the NEC infrared pulse decoder.
// Depends on nothing; every other file in hdl/ imports it.
package nec_ir_pkg;

  localparam int FRAME_BITS   = 32;
  localparam int PERIOD_W     = 16;
  localparam int TICK_W       = 32;
  localparam int CODE_W       = 32;
  localparam int BITS_W       = 6;
  localparam int RECENCY_W    = 8;
  localparam int APB_ADDR_W   = 5;
  localparam int APB_DATA_W   = 32;
  localparam int S_TDATA_W    = 48;
  localparam int M_TDATA_W    = 40;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RECV   = 2'd1,
    PH_DONE   = 2'd2,
    PH_REPEAT = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_REPEAT_LOW     = 3'd0,
    REG_REPEAT_HIGH    = 3'd1,
    REG_PREAMBLE_LOW   = 3'd2,
    REG_PREAMBLE_HIGH  = 3'd3,
    REG_ONE_LOW        = 3'd4,
    REG_ONE_HIGH       = 3'd5,
    REG_REPEAT_RECENCY = 3'd6
  } reg_idx_t;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_ACK     = 1'b1;

  localparam logic [PERIOD_W-1:0]  RST_REPEAT_LOW     = 16'd27375;
  localparam logic [PERIOD_W-1:0]  RST_REPEAT_HIGH    = 16'd28875;
  localparam logic [PERIOD_W-1:0]  RST_PREAMBLE_LOW   = 16'd33000;
  localparam logic [PERIOD_W-1:0]  RST_PREAMBLE_HIGH  = 16'd34500;
  localparam logic [PERIOD_W-1:0]  RST_ONE_LOW        = 16'd5388;
  localparam logic [PERIOD_W-1:0]  RST_ONE_HIGH       = 16'd5788;
  localparam logic [RECENCY_W-1:0] RST_REPEAT_RECENCY = 8'd9;

  typedef struct packed {
    logic [PERIOD_W-1:0]  repeat_low;
    logic [PERIOD_W-1:0]  repeat_high;
    logic [PERIOD_W-1:0]  preamble_low;
    logic [PERIOD_W-1:0]  preamble_high;
    logic [PERIOD_W-1:0]  one_low;
    logic [PERIOD_W-1:0]  one_high;
    logic [RECENCY_W-1:0] repeat_recency;
  } cfg_t;

  typedef struct packed {
    logic                op;
    logic [PERIOD_W-1:0] period;
    logic [TICK_W-1:0]   now_tick;
  } item_t;

  typedef struct packed {
    phase_t            phase;
    logic [CODE_W-1:0] code;
    logic [BITS_W-1:0] bits_seen;
  } result_t;

  // Data bit n lands in byte (3 - n/8) of the word, LSB first within the byte.
  function automatic logic [4:0] word_bit_for(input logic [4:0] n);
    word_bit_for = {~n[4:3], n[2:0]};
  endfunction

  // Exclusive window test; empty or inverted windows never match.
  function automatic logic in_window(input logic [PERIOD_W-1:0] v,
                                     input logic [PERIOD_W-1:0] lo,
                                     input logic [PERIOD_W-1:0] hi);
    in_window = (v > lo) && (v < hi);
  endfunction

endpackage

[hdl/nec_ir_cfg.sv]
// APB-style register file holding the decoder windows and repeat recency.
// Depends on nec_ir_pkg.
module nec_ir_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nec_ir_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nec_ir_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nec_ir_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  output nec_ir_pkg::cfg_t                 cfg
);
  import nec_ir_pkg::*;

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.repeat_low     <= RST_REPEAT_LOW;
      regs.repeat_high    <= RST_REPEAT_HIGH;
      regs.preamble_low   <= RST_PREAMBLE_LOW;
      regs.preamble_high  <= RST_PREAMBLE_HIGH;
      regs.one_low        <= RST_ONE_LOW;
      regs.one_high       <= RST_ONE_HIGH;
      regs.repeat_recency <= RST_REPEAT_RECENCY;
    end else if (wr_en) begin
      case (idx)
        REG_REPEAT_LOW:     regs.repeat_low     <= pwdata[PERIOD_W-1:0];
        REG_REPEAT_HIGH:    regs.repeat_high    <= pwdata[PERIOD_W-1:0];
        REG_PREAMBLE_LOW:   regs.preamble_low   <= pwdata[PERIOD_W-1:0];
        REG_PREAMBLE_HIGH:  regs.preamble_high  <= pwdata[PERIOD_W-1:0];
        REG_ONE_LOW:        regs.one_low        <= pwdata[PERIOD_W-1:0];
        REG_ONE_HIGH:       regs.one_high       <= pwdata[PERIOD_W-1:0];
        REG_REPEAT_RECENCY: regs.repeat_recency <= pwdata[RECENCY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REPEAT_LOW:     prdata = APB_DATA_W'(regs.repeat_low);
      REG_REPEAT_HIGH:    prdata = APB_DATA_W'(regs.repeat_high);
      REG_PREAMBLE_LOW:   prdata = APB_DATA_W'(regs.preamble_low);
      REG_PREAMBLE_HIGH:  prdata = APB_DATA_W'(regs.preamble_high);
      REG_ONE_LOW:        prdata = APB_DATA_W'(regs.one_low);
      REG_ONE_HIGH:       prdata = APB_DATA_W'(regs.one_high);
      REG_REPEAT_RECENCY: prdata = APB_DATA_W'(regs.repeat_recency);
      default:            prdata = '0;
    endcase
  end

endmodule

[hdl/nec_ir_core.sv]
// Decode state machine: classifies one registered item and updates the
// receive state. Depends on nec_ir_pkg.
module nec_ir_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  nec_ir_pkg::item_t   item,
  input  nec_ir_pkg::cfg_t    cfg,
  output nec_ir_pkg::result_t result
);
  import nec_ir_pkg::*;

  phase_t            phase, phase_next;
  logic [CODE_W-1:0] code, code_next;
  logic [BITS_W-1:0] bit_pos, bit_pos_next;
  logic [TICK_W-1:0] last_tick, last_tick_next;

  logic [TICK_W-1:0] elapsed;
  logic              is_capture, hit_repeat, hit_preamble, hit_one, frame_full;

  assign is_capture   = (item.op == OP_CAPTURE);
  assign elapsed      = item.now_tick - last_tick;
  assign hit_repeat   = is_capture
                        && in_window(item.period, cfg.repeat_low, cfg.repeat_high)
                        && (elapsed < TICK_W'(cfg.repeat_recency));
  assign hit_preamble = is_capture && (phase == PH_IDLE)
                        && in_window(item.period, cfg.preamble_low, cfg.preamble_high);
  assign hit_one      = in_window(item.period, cfg.one_low, cfg.one_high);
  assign frame_full   = ((bit_pos + BITS_W'(1)) >= BITS_W'(FRAME_BITS));

  // next phase
  always_comb begin
    phase_next = phase;
    if (!is_capture) begin
      if (phase == PH_DONE || phase == PH_REPEAT) phase_next = PH_IDLE;
    end else if (hit_repeat) begin
      phase_next = PH_REPEAT;
    end else if (hit_preamble) begin
      phase_next = PH_RECV;
    end else if (phase == PH_RECV && frame_full) begin
      phase_next = PH_DONE;
    end
  end

  // datapath
  always_comb begin
    code_next      = code;
    bit_pos_next   = bit_pos;
    last_tick_next = last_tick;
    if (hit_repeat) begin
      last_tick_next = item.now_tick;
    end else if (hit_preamble) begin
      code_next      = '0;
      bit_pos_next   = '0;
      last_tick_next = item.now_tick;
    end else if (is_capture && phase == PH_RECV) begin
      if (hit_one) code_next[word_bit_for(bit_pos[4:0])] = 1'b1;
      bit_pos_next = bit_pos + BITS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      code      <= '0;
      bit_pos   <= '0;
      last_tick <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      code      <= code_next;
      bit_pos   <= bit_pos_next;
      last_tick <= last_tick_next;
    end
  end

  assign result.phase     = phase_next;
  assign result.code      = code_next;
  assign result.bits_seen = bit_pos_next;

endmodule

[hdl/nec_ir_pulse_decoder.sv]
// Top level of the NEC infrared pulse decoder: input register, decode core,
// result register and APB register file. Depends on nec_ir_pkg, nec_ir_cfg, nec_ir_core.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s_axis   | in  | s_tvalid / s_tready    | tdata: period[15:0], now_tick[47:16]; tuser: op
//  m_axis   | out | m_tvalid / m_tready    | tdata: phase[1:0], code[33:2], bits_seen[39:34]
//  apb      | in  | psel, penable, pready  | 7 registers at byte address 4*i
//
// One result beat per input beat, one beat per cycle sustained while m_tready is high;
// each item passes the input register, then is decoded into the result register.
// The critical path is the 16-bit window compares and the 32-bit tick
// subtract feeding the phase select.
// rst is synchronous and active high: phase idle, code, bit count and
// reception tick cleared, registers back to their defaults.
// A stalled output holds its beat; the input register still takes one more
// beat behind it, so the upstream side stalls only when both are full.
module nec_ir_pulse_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: period[15:0], now_tick[47:16]
  input  logic [nec_ir_pkg::S_TDATA_W-1:0]  s_tdata,
  // s_tuser: op[0]
  input  logic                              s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // m_tdata: phase[1:0], code[33:2], bits_seen[39:34]
  output logic [nec_ir_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nec_ir_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nec_ir_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nec_ir_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready
);
  import nec_ir_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t result;
  result_t out_beat;

  nec_ir_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // an item moves on when the result register is free or being emptied
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op       <= s_tuser;
      in_item.period   <= s_tdata[PERIOD_W-1:0];
      in_item.now_tick <= s_tdata[PERIOD_W+TICK_W-1:PERIOD_W];
    end
  end

  nec_ir_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_beat <= result;
  end

  assign m_tdata = {out_beat.bits_seen, out_beat.code, out_beat.phase};

endmodule
